>>> rtl/sdslru_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdslru_pkg
// Types and constants shared by the replacement engine.
// ----------------------------------------------------------------------------
package sdslru_pkg;

    localparam int NUM_SETS_DEF       = 2048;
    localparam int NUM_WAYS_DEF       = 16;
    localparam int HISTORY_DEPTH_DEF  = 4;
    localparam int LEADER_PAIRS_DEF   = 32;
    localparam int SELECTOR_WIDTH_DEF = 10;

    localparam int ADDR_W   = 48;
    localparam int SET_IN_W = 11;
    localparam int WAY_W    = 4;
    localparam int MASK_W   = 16;
    localparam int POS_W    = 4;
    localparam int SEL_OUT_W = 10;
    localparam int REUSE_W  = 2;
    localparam int LFSR_W   = 16;

    localparam logic [1:0]  REUSE_MAX    = 2'd3;
    localparam logic [1:0]  REUSE_STRONG = 2'd2;
    localparam logic [1:0]  REUSE_FILL   = 2'd1;
    localparam logic [15:0] LFSR_SEED    = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS    = 16'hB400;
    localparam int          BIP_BITS     = 5;

    typedef enum logic [1:0]
    {
        ROLE_FOLLOW,
        ROLE_LIP,
        ROLE_BIP
    } role_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_CLEAR
    } state_t;

    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

endpackage
`default_nettype wire

>>> rtl/sdslru_role.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdslru_role
// Classifies a set as a LIP leader, a BIP leader or a follower.
// ----------------------------------------------------------------------------
module sdslru_role #(
    parameter int NUM_SETS     = sdslru_pkg::NUM_SETS_DEF,
    parameter int LEADER_PAIRS = sdslru_pkg::LEADER_PAIRS_DEF,
    parameter int SET_W        = $clog2(NUM_SETS)
) (
    input  wire logic [SET_W-1:0] set_sel,
    output sdslru_pkg::role_t     role
);
    localparam int HALF = NUM_SETS / 2;

    always_comb
    begin
        logic [63:0] lip;
        logic [63:0] bip;
        role = sdslru_pkg::ROLE_FOLLOW;
        for (int i = 0; i < LEADER_PAIRS; i++)
        begin
            lip = (64'(i) * 64'(NUM_SETS)) / 64'(2 * LEADER_PAIRS);
            bip = (lip + 64'(HALF)) % 64'(NUM_SETS);
            if (64'(set_sel) == bip)
                role = sdslru_pkg::ROLE_BIP;
            else if (64'(set_sel) == lip && role != sdslru_pkg::ROLE_BIP)
                role = sdslru_pkg::ROLE_LIP;
        end
    end
endmodule
`default_nettype wire

>>> rtl/set_dueling_stream_aware_lru.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_dueling_stream_aware_lru
// Cache replacement engine with recency stacks, set dueling and stride check.
// ----------------------------------------------------------------------------
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | cmd set_index way valid_mask address hit
// out     | output    | out_valid/out_stall | victim_way streaming_seen insert_position
//         |           |                   | policy_select
// An item passes through accept, the set memory read in ST_READ and, in ST_WRITE,
// the result and, for an update, the modify and write back of its set and history rows.
// After reset a clearing pass in ST_CLEAR initialises the memories,
// one set row per cycle; no item is accepted meanwhile.
// A result waits in the output register; the next item is accepted while it
// waits, but its result is only written once the register is free.
// ----------------------------------------------------------------------------
module set_dueling_stream_aware_lru #(
    parameter int NUM_SETS       = sdslru_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS       = sdslru_pkg::NUM_WAYS_DEF,
    parameter int HISTORY_DEPTH  = sdslru_pkg::HISTORY_DEPTH_DEF,
    parameter int LEADER_PAIRS   = sdslru_pkg::LEADER_PAIRS_DEF,
    parameter int SELECTOR_WIDTH = sdslru_pkg::SELECTOR_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [10:0] set_index,
    input  wire logic [3:0]  way,
    input  wire logic [15:0] valid_mask,
    input  wire logic [47:0] address,
    input  wire logic        hit,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       victim_way,
    output logic             streaming_seen,
    output logic [3:0]       insert_position,
    output logic [9:0]       policy_select
);
    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int PW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int AW    = sdslru_pkg::ADDR_W;
    localparam int RW    = sdslru_pkg::REUSE_W;
    localparam int SW    = SELECTOR_WIDTH;
    localparam logic [SW-1:0] SEL_MAX  = {SW{1'b1}};
    localparam logic [SW-1:0] SEL_HALF = {1'b1, {(SW-1){1'b0}}};
    localparam logic [3:0]    LRU      = 4'(NUM_WAYS - 1);

    typedef logic [NUM_WAYS-1:0][3:0]            rec_row_t;
    typedef logic [NUM_WAYS-1:0][RW-1:0]         reu_row_t;
    typedef logic [HISTORY_DEPTH-1:0][AW-1:0]    his_row_t;

    rec_row_t       rec_mem [NUM_SETS];
    reu_row_t       reu_mem [NUM_SETS];
    his_row_t       his_mem [NUM_SETS];
    logic [PW-1:0]  ptr_mem [NUM_SETS];

    rec_row_t       rec_rd_reg;
    reu_row_t       reu_rd_reg;
    his_row_t       his_rd_reg;
    logic [PW-1:0]  ptr_rd_reg;

    sdslru_pkg::state_t state_reg, state_next;
    logic [SET_W:0]     clr_reg, clr_next;
    logic [SW-1:0]      sel_reg, sel_next;
    logic [15:0]        lfsr_reg, lfsr_next;

    logic               cmd_reg;
    logic [SET_W-1:0]   set_reg;
    logic [WW-1:0]      way_reg;
    logic [15:0]        mask_reg;
    logic [AW-1:0]      addr_reg;
    logic               hit_reg;

    logic               out_valid_reg, out_valid_next;
    logic [3:0]         vic_reg;
    logic               str_reg;
    logic [3:0]         pos_reg;

    logic               accept;
    logic               wr_en;
    logic [SET_W-1:0]   wr_set;
    rec_row_t           rec_wr;
    reu_row_t           reu_wr;
    his_row_t           his_wr;
    logic [PW-1:0]      ptr_wr;
    logic [3:0]         vic_c;
    logic               str_c;
    logic [3:0]         pos_c;
    sdslru_pkg::role_t  role;

    sdslru_role #(
        .NUM_SETS     (NUM_SETS),
        .LEADER_PAIRS (LEADER_PAIRS),
        .SET_W        (SET_W)
    ) u_role (
        .set_sel (set_reg),
        .role    (role)
    );

    assign in_stall = (state_reg != sdslru_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_mem[wr_set] <= rec_wr;
            reu_mem[wr_set] <= reu_wr;
            his_mem[wr_set] <= his_wr;
            ptr_mem[wr_set] <= ptr_wr;
        end
        rec_rd_reg <= rec_mem[set_reg];
        reu_rd_reg <= reu_mem[set_reg];
        his_rd_reg <= his_mem[set_reg];
        ptr_rd_reg <= ptr_mem[set_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            set_reg  <= SET_W'(32'(set_index) % NUM_SETS);
            way_reg  <= WW'(32'(way) % NUM_WAYS);
            mask_reg <= valid_mask;
            addr_reg <= address;
            hit_reg  <= hit;
        end
        if (state_reg == sdslru_pkg::ST_WRITE && !(out_valid_reg && out_stall))
        begin
            vic_reg <= vic_c;
            str_reg <= str_c;
            pos_reg <= pos_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdslru_pkg::ST_CLEAR;
            clr_reg       <= '0;
            sel_reg       <= SEL_HALF;
            lfsr_reg      <= sdslru_pkg::LFSR_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sel_reg       <= sel_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        logic [3:0]    old;
        logic [3:0]    best;
        logic          found;
        logic [RW-1:0] ctr;
        logic [3:0]    pos;
        logic          draw;
        logic [15:0]   lf;
        logic [AW-1:0] first;
        logic [PW-1:0] p;
        logic          done;

        state_next     = state_reg;
        clr_next       = clr_reg;
        sel_next       = sel_reg;
        lfsr_next      = lfsr_reg;
        out_valid_next = out_valid_reg && out_stall;
        wr_en          = 1'b0;
        wr_set         = set_reg;
        rec_wr         = rec_rd_reg;
        reu_wr         = reu_rd_reg;
        his_wr         = his_rd_reg;
        ptr_wr         = ptr_rd_reg;
        vic_c          = '0;
        str_c          = 1'b0;
        pos_c          = '0;
        old            = '0;
        best           = '0;
        found          = 1'b0;
        ctr            = '0;
        pos            = LRU;
        draw           = 1'b0;
        lf             = lfsr_reg;
        first          = '0;
        p              = '0;
        done           = 1'b0;

        if (cmd_reg == sdslru_pkg::CMD_QUERY)
        begin
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                if (!found && !mask_reg[i])
                begin
                    vic_c = 4'(i);
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                best = rec_rd_reg[0];
                for (int i = 1; i < NUM_WAYS; i++)
                begin
                    if (rec_rd_reg[i] > best)
                    begin
                        best  = rec_rd_reg[i];
                        vic_c = 4'(i);
                    end
                end
            end
        end
        else
        begin
            p = (32'(ptr_rd_reg) >= HISTORY_DEPTH) ? '0 : ptr_rd_reg;
            his_wr[p] = addr_reg;
            ptr_wr = (32'(p) == HISTORY_DEPTH - 1) ? '0 : PW'(32'(p) + 1);
            if (32'(p) == HISTORY_DEPTH - 1)
            begin
                first = his_wr[1] - his_wr[0];
                str_c = 1'b1;
                for (int i = 2; i < HISTORY_DEPTH; i++)
                    if ((his_wr[i] - his_wr[i-1]) != first)
                        str_c = 1'b0;
            end
            if (hit_reg)
            begin
                old = rec_rd_reg[way_reg];
                for (int i = 0; i < NUM_WAYS; i++)
                    if (rec_rd_reg[i] < old)
                        rec_wr[i] = rec_rd_reg[i] + 4'd1;
                rec_wr[way_reg] = '0;
                if (reu_rd_reg[way_reg] < sdslru_pkg::REUSE_MAX)
                    reu_wr[way_reg] = reu_rd_reg[way_reg] + 2'd1;
            end
            else
            begin
                ctr = reu_rd_reg[way_reg];
                if (ctr > 0)
                    ctr = ctr - 2'd1;
                draw = (role == sdslru_pkg::ROLE_BIP) ||
                       (role == sdslru_pkg::ROLE_FOLLOW && sel_reg < SEL_HALF);
                if (draw)
                begin
                    lf = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? sdslru_pkg::LFSR_TAPS : 16'h0);
                    pos = (lf[sdslru_pkg::BIP_BITS-1:0] == '0) ? 4'd0 : LRU;
                end
                if (ctr >= sdslru_pkg::REUSE_STRONG)
                    pos = 4'd0;
                else if (str_c)
                    pos = LRU;
                for (int i = 0; i < NUM_WAYS; i++)
                    if (WW'(i) != way_reg && rec_rd_reg[i] < pos)
                        rec_wr[i] = rec_rd_reg[i] + 4'd1;
                rec_wr[way_reg] = pos;
                reu_wr[way_reg] = sdslru_pkg::REUSE_FILL;
                pos_c = pos;
            end
        end

        case (state_reg)
            sdslru_pkg::ST_CLEAR:
            begin
                wr_en  = 1'b1;
                wr_set = clr_reg[SET_W-1:0];
                rec_wr = '0;
                for (int i = 0; i < NUM_WAYS; i++)
                    reu_wr[i] = sdslru_pkg::REUSE_FILL;
                his_wr = '0;
                ptr_wr = '0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == NUM_SETS - 1)
                    state_next = sdslru_pkg::ST_IDLE;
            end
            sdslru_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = sdslru_pkg::ST_READ;
            end
            sdslru_pkg::ST_READ:
            begin
                state_next = sdslru_pkg::ST_WRITE;
            end
            sdslru_pkg::ST_WRITE:
            begin
                done = !(out_valid_reg && out_stall);
                if (done)
                begin
                    wr_en          = (cmd_reg == sdslru_pkg::CMD_UPDATE);
                    out_valid_next = 1'b1;
                    state_next     = sdslru_pkg::ST_IDLE;
                    if (cmd_reg == sdslru_pkg::CMD_UPDATE && !hit_reg)
                    begin
                        lfsr_next = lf;
                        if (role == sdslru_pkg::ROLE_LIP && sel_reg > 0)
                            sel_next = sel_reg - 1'b1;
                        else if (role == sdslru_pkg::ROLE_BIP && sel_reg < SEL_MAX)
                            sel_next = sel_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = sdslru_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign victim_way      = vic_reg;
    assign streaming_seen  = str_reg;
    assign insert_position = pos_reg;
    assign policy_select   = 10'(sel_reg);

    a_stall_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdslru_pkg::ST_READ) |-> in_stall)
        else $error("Input taken while an item is in flight.");
    a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdslru_pkg::ST_READ) |=> (state_reg == sdslru_pkg::ST_WRITE))
        else $error("Read cycle not followed by the write-back cycle.");
    a_sel_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sdslru_pkg::ST_WRITE) |=> $stable(sel_reg))
        else $error("Selector moved outside a write-back cycle.");
endmodule
`default_nettype wire

>>> test/set_dueling_stream_aware_lru_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_dueling_stream_aware_lru_tb
// Self-checking bench for the replacement engine. A directed table and a
// random part drive queries and updates; a behavioural predictor of the
// recency stacks, stride detector and selector works out every result, which
// is compared field by field with the block's output.
// ----------------------------------------------------------------------------
module set_dueling_stream_aware_lru_tb;

    localparam int NSETS = 2048;
    localparam int NWAYS = 16;
    localparam int HDEPTH = 4;
    localparam int NPAIRS = 32;
    localparam logic [9:0] SEL_HALF = 10'd512;
    localparam logic [9:0] SEL_TOP = 10'd1023;
    localparam logic [47:0] ADDR_ALL = 48'hFFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       cmd;
        logic [10:0] set_index;
        logic [3:0] way;
        logic [15:0] valid_mask;
        logic [47:0] address;
        logic       hit;
    } item_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       streaming_seen;
        logic [3:0] insert_position;
        logic [9:0] policy_select;
    } verdict_t;

    typedef struct {
        item_t stim;
        logic  known;
        verdict_t res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = 1'b0;
    logic [10:0] set_index = '0;
    logic [3:0] way = '0;
    logic [15:0] valid_mask = '0;
    logic [47:0] address = '0;
    logic hit = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] victim_way;
    logic streaming_seen;
    logic [3:0] insert_position;
    logic [9:0] policy_select;

    set_dueling_stream_aware_lru u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .set_index(set_index), .way(way), .valid_mask(valid_mask),
        .address(address), .hit(hit),
        .out_valid(out_valid), .out_stall(out_stall),
        .victim_way(victim_way), .streaming_seen(streaming_seen),
        .insert_position(insert_position), .policy_select(policy_select)
    );

    always #5 clk = ~clk;

    logic [3:0] recency [NSETS][NWAYS];
    logic [1:0] reuse [NSETS][NWAYS];
    logic [47:0] addr_ring [NSETS][HDEPTH];
    int unsigned ring_ptr [NSETS];
    logic [9:0] selector;
    logic [15:0] lfsr;

    verdict_t pending_results [$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit long_hold = 1'b0;
    int hold_off = 0;

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic sdslru_pkg::role_t role_of(input int s);
        sdslru_pkg::role_t r;
        int lip;
        int bip;
        r = sdslru_pkg::ROLE_FOLLOW;
        for (int i = 0; i < NPAIRS; i++)
        begin
            lip = (i * NSETS) / (2 * NPAIRS);
            bip = (lip + NSETS / 2) % NSETS;
            if (s == bip)
                r = sdslru_pkg::ROLE_BIP;
            else if (s == lip && r != sdslru_pkg::ROLE_BIP)
                r = sdslru_pkg::ROLE_LIP;
        end
        return r;
    endfunction

    function automatic bit bimodal_draw();
        logic lsb;
        lsb = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb)
            lfsr = lfsr ^ sdslru_pkg::LFSR_TAPS;
        return lfsr[4:0] == 5'd0;
    endfunction

    function automatic bit stride_seen(input int s, input logic [47:0] a);
        int unsigned p;
        logic [47:0] first;
        bit same;
        p = ring_ptr[s];
        addr_ring[s][p] = a;
        ring_ptr[s] = (p + 1) % HDEPTH;
        if (p < HDEPTH - 1)
            return 1'b0;
        first = addr_ring[s][1] - addr_ring[s][0];
        same = 1'b1;
        for (int i = 2; i < HDEPTH; i++)
            if (addr_ring[s][i] - addr_ring[s][i - 1] != first)
                same = 1'b0;
        return same;
    endfunction

    function automatic verdict_t replace_step(input item_t it);
        verdict_t v;
        int s;
        int w;
        logic [3:0] old;
        logic [3:0] pos;
        logic [1:0] ctr;
        logic [3:0] best;
        sdslru_pkg::role_t r;
        bit found;
        v = '0;
        s = it.set_index;
        w = it.way;
        if (it.cmd == sdslru_pkg::CMD_QUERY)
        begin
            found = 1'b0;
            for (int i = 0; i < NWAYS; i++)
                if (!found && !it.valid_mask[i])
                begin
                    v.victim_way = 4'(i);
                    found = 1'b1;
                end
            if (!found)
            begin
                best = recency[s][0];
                for (int i = 1; i < NWAYS; i++)
                    if (recency[s][i] > best)
                    begin
                        best = recency[s][i];
                        v.victim_way = 4'(i);
                    end
            end
        end
        else
        begin
            v.streaming_seen = stride_seen(s, it.address);
            if (it.hit)
            begin
                old = recency[s][w];
                for (int i = 0; i < NWAYS; i++)
                    if (recency[s][i] < old)
                        recency[s][i]++;
                recency[s][w] = 4'd0;
                if (reuse[s][w] < sdslru_pkg::REUSE_MAX)
                    reuse[s][w]++;
            end
            else
            begin
                r = role_of(s);
                pos = 4'(NWAYS - 1);
                ctr = reuse[s][w];
                if (ctr > 0)
                    ctr--;
                if (r == sdslru_pkg::ROLE_BIP ||
                    (r == sdslru_pkg::ROLE_FOLLOW && selector < SEL_HALF))
                    pos = bimodal_draw() ? 4'd0 : 4'(NWAYS - 1);
                if (ctr >= sdslru_pkg::REUSE_STRONG)
                    pos = 4'd0;
                else if (v.streaming_seen)
                    pos = 4'(NWAYS - 1);
                recency[s][w] = pos;
                for (int i = 0; i < NWAYS; i++)
                    if (i != w && recency[s][i] < pos)
                        recency[s][i]++;
                reuse[s][w] = sdslru_pkg::REUSE_FILL;
                if (r == sdslru_pkg::ROLE_LIP && selector > 0)
                    selector--;
                else if (r == sdslru_pkg::ROLE_BIP && selector < SEL_TOP)
                    selector++;
                v.insert_position = pos;
            end
        end
        v.policy_select = selector;
        return v;
    endfunction

    function automatic item_t mk(input logic c, input int s, input int w,
                                 input logic [15:0] m, input logic [47:0] a,
                                 input logic h);
        item_t it;
        it.cmd = c;
        it.set_index = 11'(s);
        it.way = 4'(w);
        it.valid_mask = m;
        it.address = a;
        it.hit = h;
        return it;
    endfunction

    task automatic send(input item_t it, input bit gaps);
        if (gaps && !quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        {cmd, set_index, way, valid_mask, address, hit} <= it;
        in_valid <= 1'b1;
        pending_results.push_back(replace_step(it));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_known(input row_t row);
        verdict_t p;
        send(row.stim, 1'b1);
        p = pending_results[$];
        if (row.known && p !== row.res)
            report("table row", p, row.res);
    endtask

    function automatic item_t random_item(input int mode);
        item_t it;
        it.cmd = $urandom_range(0, 2) != 0;
        it.set_index = 11'($urandom_range(0, 2047));
        it.way = 4'($urandom);
        it.valid_mask = 16'($urandom);
        it.address = {16'($urandom), $urandom};
        it.hit = 1'($urandom);
        if (mode == 0)
            it.set_index = 11'($urandom_range(0, 7) * 32);
        else if (mode == 1)
            it.set_index = 11'(1024 + $urandom_range(0, 3) * 32);
        else if (mode == 2)
            it.set_index = 11'($urandom_range(1, 6));
        if ($urandom_range(0, 2) == 0)
            it.valid_mask = 16'hFFFF;
        return it;
    endfunction

    // Receiver side: random stall bursts, one long hold-off and a quiet tail.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (long_hold)
        begin
            long_hold = 1'b0;
            out_stall <= 1'b1;
            hold_off <= 60;
        end
        else if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            hold_off <= $urandom_range(0, 10);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report("unexpected result", 0, 0);
            else
            begin
                automatic verdict_t e = pending_results.pop_front();
                if (victim_way !== e.victim_way)
                    report("victim_way", victim_way, e.victim_way);
                if (streaming_seen !== e.streaming_seen)
                    report("streaming_seen", streaming_seen, e.streaming_seen);
                if (insert_position !== e.insert_position)
                    report("insert_position", insert_position, e.insert_position);
                if (policy_select !== e.policy_select)
                    report("policy_select", policy_select, e.policy_select);
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("set_dueling_stream_aware_lru regression: fail");
        $finish;
    end

    initial
    begin
        row_t table_rows [$];
        item_t it;
        logic [47:0] base;
        logic [47:0] step;
        int s;
        bit paused;
        paused = 1'b0;
        for (int i = 0; i < NSETS; i++)
        begin
            ring_ptr[i] = 0;
            for (int j = 0; j < NWAYS; j++)
            begin
                recency[i][j] = 4'd0;
                reuse[i][j] = sdslru_pkg::REUSE_FILL;
            end
            for (int j = 0; j < HDEPTH; j++)
                addr_ring[i][j] = 48'd0;
        end
        selector = SEL_HALF;
        lfsr = sdslru_pkg::LFSR_SEED;

        table_rows.push_back('{mk(sdslru_pkg::CMD_QUERY, 0, 0, 16'hFFFF, 0, 0), 1,
                               '{0, 0, 0, SEL_HALF}});
        table_rows.push_back('{mk(sdslru_pkg::CMD_QUERY, 2047, 15, 16'h0000, ADDR_ALL, 1), 1,
                               '{0, 0, 0, SEL_HALF}});
        table_rows.push_back('{mk(sdslru_pkg::CMD_QUERY, 5, 0, 16'h7FFF, 0, 0), 1,
                               '{15, 0, 0, SEL_HALF}});
        table_rows.push_back('{mk(sdslru_pkg::CMD_QUERY, 5, 0, 16'hFEFF, 0, 0), 1,
                               '{8, 0, 0, SEL_HALF}});
        table_rows.push_back('{mk(sdslru_pkg::CMD_UPDATE, 0, 3, 0, 0, 0), 1,
                               '{0, 0, 15, 10'd511}});
        table_rows.push_back('{mk(sdslru_pkg::CMD_UPDATE, 1024, 4, 0, 0, 0), 0, '0});
        table_rows.push_back('{mk(sdslru_pkg::CMD_UPDATE, 7, 15, 16'hFFFF, ADDR_ALL, 1), 0, '0});
        for (int k = 0; k < 4; k++)
            table_rows.push_back('{mk(sdslru_pkg::CMD_UPDATE, 9, k, 0, 48'h100 + 64 * k, 0),
                                   0, '0});
        for (int k = 0; k < 4; k++)
            table_rows.push_back('{mk(sdslru_pkg::CMD_UPDATE, 9, 5, 0, ADDR_ALL - k, 1), 0, '0});
        for (int k = 0; k < 4; k++)
            table_rows.push_back('{mk(sdslru_pkg::CMD_UPDATE, 11, 2, 0, 48'h1000 * k * k, 1),
                                   0, '0});
        table_rows.push_back('{mk(sdslru_pkg::CMD_QUERY, 9, 0, 16'hFFFF, 0, 0), 0, '0});
        table_rows.push_back('{mk(sdslru_pkg::CMD_QUERY, 0, 0, 16'hFFFF, 0, 0), 0, '0});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send_known(table_rows[i]);

        // Long receiver hold-off while items keep coming, so the input stalls.
        long_hold = 1'b1;
        for (int i = 0; i < 20; i++)
            send(random_item(2), 1'b0);

        for (int n = 0; n < 620; n++)
        begin
            if (n >= 300 && !paused)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            if (n >= 540)
                quiet = 1'b1;
            if ($urandom_range(0, 3) == 0)
            begin
                s = $urandom_range(0, 2047);
                base = 48'({$urandom, $urandom});
                step = $urandom_range(0, 1) ? 48'd64 : 48'({$urandom, $urandom});
                for (int k = 0; k < HDEPTH; k++)
                begin
                    it = mk(sdslru_pkg::CMD_UPDATE, s, $urandom_range(0, 15), 16'($urandom),
                            base + step * k, 1'($urandom_range(0, 1)));
                    send(it, 1'b1);
                    if (k > 0)
                        n++;
                end
            end
            else
                send(random_item($urandom_range(0, 3)), 1'b1);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("set_dueling_stream_aware_lru regression: pass");
        else
            $display("set_dueling_stream_aware_lru regression: fail");
        $finish;
    end
endmodule

>>> filelist.f
rtl/sdslru_pkg.sv
rtl/sdslru_role.sv
rtl/set_dueling_stream_aware_lru.sv
test/set_dueling_stream_aware_lru_tb.sv
